// ===== sv/grid_max_path_sum_macros.svh =====
// assertion macros for the grid maximum path sum block
// used by the port checker; needs clk and rst_n in the scope of each use
`ifndef GRID_MAX_PATH_SUM_MACROS_SVH
`define GRID_MAX_PATH_SUM_MACROS_SVH

// same-cycle implication
`define GMPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gmps_pkg.sv =====
// shared constants and types for the grid maximum path sum block
// no dependencies
package gmps_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    localparam int COIN_W    = 16;
    localparam int SUM_W     = 22;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    typedef enum logic [DIR_W-1:0] {
        MOVE_DOWN  = 2'd0,
        MOVE_RIGHT = 2'd1,
        MOVE_NONE  = 2'd2
    } move_dir_t;

    // walk controller to move emitter
    typedef struct packed {
        logic             push;
        logic             push_right;
        logic             done;
        logic             single;
        logic [SUM_W-1:0] total;
    } walk_ctl_t;

endpackage

// ===== sv/gmps_emit.sv =====
// path move stack and result emitter: stores moves found walking back
// from the corner and replays them from the top-left corner onward; uses gmps_pkg
module gmps_emit
    import gmps_pkg::*;
#(
    parameter int MAX_MOVES = MAX_ROWS_DEF + MAX_COLS_DEF - 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  walk_ctl_t        ctl,
    output logic             active,
    output logic             result_valid,
    output logic [DIR_W-1:0] move_dir,
    output logic [SUM_W-1:0] best_total,
    output logic             last_move
);

    localparam int STACK_DEPTH = (MAX_MOVES > 1) ? MAX_MOVES : 1;
    localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    logic             stack_mem [STACK_DEPTH];
    logic             stack_reg;
    logic [CNT_W-1:0] wp_reg;
    logic [SP_W-1:0]  rp_reg;
    logic             active_reg;
    logic             out_valid_reg;
    logic             last_reg;
    logic             single_reg;
    logic [SUM_W-1:0] total_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stack_mem[wp_reg[SP_W-1:0]] <= ctl.push_right;
        end
        if (active_reg)
        begin
            stack_reg <= stack_mem[rp_reg];
        end
        if (ctl.done)
        begin
            total_reg <= ctl.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            single_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= active_reg;
            if (ctl.push)
            begin
                wp_reg <= wp_reg + CNT_W'(1);
            end
            if (active_reg)
            begin
                last_reg <= (rp_reg == '0);
                rp_reg   <= rp_reg - SP_W'(1);
                if (rp_reg == '0)
                begin
                    active_reg <= 1'b0;
                end
            end
            if (ctl.done)
            begin
                wp_reg     <= '0;
                single_reg <= ctl.single;
                if (ctl.single)
                begin
                    out_valid_reg <= 1'b1;
                    last_reg      <= 1'b1;
                end
                else
                begin
                    active_reg <= 1'b1;
                    // the final move may be pushed in the same cycle
                    rp_reg     <= ctl.push ? wp_reg[SP_W-1:0]
                                           : wp_reg[SP_W-1:0] - SP_W'(1);
                end
            end
        end
    end

    assign active       = active_reg;
    assign result_valid = out_valid_reg;
    assign best_total   = total_reg;
    assign last_move    = last_reg;
    assign move_dir     = single_reg ? MOVE_NONE : (stack_reg ? MOVE_RIGHT : MOVE_DOWN);

endmodule

// ===== sv/grid_max_path_sum.sv =====
// grid_max_path_sum: right/down maximum path sum, sum and coin tables in block memory
// loading: one coin word per cycle; table write is registered, in the cycle after accept, row above forwarded
// after the last cell: a read state and a decide state per move of the walk back, then one move word per cycle
// the receiver cannot stall; busy stays high after the last cell until the last move word is out
// reset: sizes 1x1, load position (0,0), tables undefined until loaded; uses gmps_pkg, gmps_emit
module grid_max_path_sum
    import gmps_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [COIN_W-1:0]    coin_value,
    output logic                 result_valid,
    output logic [DIR_W-1:0]     move_dir,
    output logic [SUM_W-1:0]     best_total,
    output logic                 last_move
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_FINISH = 5'b00010,
        S_READ   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                    input logic [CW-1:0] c);
        cell_addr = ADDR_W'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  grid_rows_reg, grid_cols_reg;
    logic [RW-1:0]     last_row, last_col_row_unused;
    logic [CW-1:0]     last_col;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     wrow_reg, wrow_next;
    logic [CW-1:0]     wcol_reg, wcol_next;

    logic              accept;
    logic [ADDR_W-1:0] load_up_addr, walk_addr, walk_up_addr, rd_a_addr;

    logic [SUM_W-1:0]  sum_mem  [CELLS];
    logic [COIN_W-1:0] coin_mem [CELLS];
    logic [SUM_W-1:0]  rd_a_reg, rd_b_reg;
    logic [COIN_W-1:0] coin_rd_reg;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [COIN_W-1:0] s1_coin_reg;
    logic              s1_has_up_reg, s1_has_left_reg, s1_fwd_reg;
    logic [SUM_W-1:0]  last_sum_reg, total_reg;
    logic [SUM_W-1:0]  up_sum, left_sum, best_sum, new_sum, via_up;

    logic              at_origin, go_down, next_origin;
    walk_ctl_t         ctl;
    logic              emit_active;

    // clamp size registers: zero counts as one, above the maximum saturates
    always_comb
    begin
        if (grid_rows_reg == '0)
            last_row = '0;
        else if (32'(grid_rows_reg) > MAX_ROWS)
            last_row = RW'(MAX_ROWS - 1);
        else
            last_row = RW'(grid_rows_reg - CFG_W'(1));
        if (grid_cols_reg == '0)
            last_col = '0;
        else if (32'(grid_cols_reg) > MAX_COLS)
            last_col = CW'(MAX_COLS - 1);
        else
            last_col = CW'(grid_cols_reg - CFG_W'(1));
    end
    assign last_col_row_unused = last_row;

    assign busy   = (state_reg != S_LOAD);
    assign accept = start && !busy;

    assign load_up_addr = cell_addr((row_reg == '0) ? '0 : row_reg - RW'(1), col_reg);
    assign walk_addr    = cell_addr(wrow_reg, wcol_reg);
    assign walk_up_addr = cell_addr((wrow_reg == '0) ? '0 : wrow_reg - RW'(1), wcol_reg);
    assign rd_a_addr    = (state_reg == S_LOAD) ? load_up_addr : walk_addr;

    // table update for the cell accepted in the previous cycle
    assign up_sum   = !s1_has_up_reg ? '0 : (s1_fwd_reg ? last_sum_reg : rd_a_reg);
    assign left_sum = s1_has_left_reg ? last_sum_reg : '0;
    assign best_sum = (up_sum > left_sum) ? up_sum : left_sum;
    assign new_sum  = best_sum + SUM_W'(s1_coin_reg);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            sum_mem[s1_addr_reg]  <= new_sum;
            coin_mem[s1_addr_reg] <= s1_coin_reg;
        end
        rd_a_reg    <= sum_mem[rd_a_addr];
        rd_b_reg    <= sum_mem[walk_up_addr];
        coin_rd_reg <= coin_mem[walk_addr];
        if (accept)
        begin
            s1_addr_reg     <= cell_addr(row_reg, col_reg);
            s1_coin_reg     <= coin_value;
            s1_has_up_reg   <= (row_reg != '0);
            s1_has_left_reg <= (col_reg != '0);
            // row above written this very cycle (single-column grid)
            s1_fwd_reg      <= s1_valid_reg && (s1_addr_reg == load_up_addr);
        end
        if (s1_valid_reg)
        begin
            last_sum_reg <= new_sum;
        end
        if (state_reg == S_FINISH)
        begin
            total_reg <= new_sum;
        end
    end

    // walk step: tie goes down
    assign via_up    = rd_b_reg + SUM_W'(coin_rd_reg);
    assign at_origin = (wrow_reg == '0) && (wcol_reg == '0);
    always_comb
    begin
        if (wrow_reg == '0)
            go_down = 1'b0;
        else if (wcol_reg == '0)
            go_down = 1'b1;
        else
            go_down = (rd_a_reg == via_up);
    end
    assign wrow_next   = go_down ? wrow_reg - RW'(1) : wrow_reg;
    assign wcol_next   = go_down ? wcol_reg : wcol_reg - CW'(1);
    assign next_origin = (wrow_next == '0) && (wcol_next == '0);

    always_comb
    begin
        ctl.push       = (state_reg == S_DECIDE) && !at_origin;
        ctl.push_right = !go_down;
        ctl.done       = (state_reg == S_DECIDE) && (at_origin || next_origin);
        ctl.single     = at_origin;
        ctl.total      = total_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (col_reg == last_col)
                    begin
                        col_next = '0;
                        if (row_reg == last_row)
                        begin
                            row_next   = '0;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            S_FINISH: state_next = S_READ;
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = ctl.done ? S_EMIT : S_READ;
            S_EMIT:   state_next = emit_active ? S_EMIT : S_LOAD;
            default:  state_next = S_LOAD;
        endcase
        if (cfg_write && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS))
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            grid_rows_reg <= CFG_W'(1);
            grid_cols_reg <= CFG_W'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            wrow_reg      <= '0;
            wcol_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= accept;
            if (cfg_write && cfg_index == REG_GRID_ROWS)
            begin
                grid_rows_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_GRID_COLS)
            begin
                grid_cols_reg <= cfg_data;
            end
            if (state_reg == S_FINISH)
            begin
                wrow_reg <= last_col_row_unused;
                wcol_reg <= last_col;
            end
            else if (state_reg == S_DECIDE)
            begin
                wrow_reg <= wrow_next;
                wcol_reg <= wcol_next;
            end
        end
    end

    gmps_emit #(
        .MAX_MOVES (MAX_ROWS + MAX_COLS - 2)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .active       (emit_active),
        .result_valid (result_valid),
        .move_dir     (move_dir),
        .best_total   (best_total),
        .last_move    (last_move)
    );

endmodule

// ===== sv/gmps_checker.sv =====
// port-level checks for grid_max_path_sum, attached by bind
// uses gmps_pkg and grid_max_path_sum_macros.svh
`include "grid_max_path_sum_macros.svh"

module gmps_checker
    import gmps_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             busy,
    input logic             result_valid,
    input logic [DIR_W-1:0] move_dir,
    input logic [SUM_W-1:0] best_total,
    input logic             last_move
);

    // moves of one path come out back to back
    `GMPS_ASSERT_NEXT(a_moves_contiguous, result_valid && !last_move, result_valid, "path moves not contiguous")

    // no new cell is taken before the last move of a path is out
    `GMPS_ASSERT_NOW(a_busy_during_path, result_valid && !last_move, busy, "idle while path still streaming")

    // one total for the whole path
    `GMPS_ASSERT_NOW(a_total_steady, result_valid && $past(result_valid) && !$past(last_move), $stable(best_total), "total changed within a path")

    // the no-move word is always marked as the last word of its path
    `GMPS_ASSERT_NOW(a_none_is_last, result_valid && move_dir == MOVE_NONE, last_move, "no-move word not marked last")

endmodule

bind grid_max_path_sum gmps_checker u_gmps_checker (.*);
